// File: hw/rtl/vfr_pkg.sv
// Shared widths, constants, codes and types of the volume fade ramp.
`default_nettype none
package vfr_pkg;

  localparam int LVL_W  = 9;   // Q8 level, 256 is unity
  localparam int MS_W   = 16;  // fade time in milliseconds
  localparam int CNT_W  = 16;  // sample count and chunk length
  localparam int LEN_W  = 25;  // step length and countdown
  localparam int DEN_W  = 11;  // divisor of the step length
  localparam int STEP_CNT_W = $clog2(LEN_W);

  localparam int unsigned RATE_NUM = 441;
  localparam int unsigned DEN_MUL  = 10;
  localparam int unsigned STEP_MIN = 12;
  localparam int unsigned LVL_STEP = 4;

  localparam logic ACT_RETARGET = 1'b0;
  localparam logic ACT_ADVANCE  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } vfr_state_t;

  // Operation handed to the fader state, applied when commit is high
  typedef struct packed {
    logic             commit;
    logic             is_adv;
    logic [LVL_W-1:0] tgt;
    logic [CNT_W-1:0] n;
    logic [LEN_W-1:0] len;
  } vfr_op_t;

  typedef struct packed {
    logic [CNT_W-1:0] chunk;
    logic [LVL_W-1:0] level_after;
  } vfr_res_t;

endpackage
`default_nettype wire

// File: hw/rtl/vfr_ifs.sv
// Valid/ready stream interfaces for the input and result items.
`default_nettype none
interface vfr_in_if;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [vfr_pkg::LVL_W-1:0] target_level;
  logic [vfr_pkg::MS_W-1:0]  fade_ms;
  logic [vfr_pkg::CNT_W-1:0] sample_count;

  modport source (output valid, action, target_level, fade_ms, sample_count,
                  input ready);
  modport sink (input valid, action, target_level, fade_ms, sample_count,
                output ready);
endinterface

interface vfr_out_if;
  logic                      valid;
  logic                      ready;
  logic [vfr_pkg::CNT_W-1:0] chunk_len;
  logic [vfr_pkg::LVL_W-1:0] level_before;
  logic [vfr_pkg::LVL_W-1:0] level_after;

  modport source (output valid, chunk_len, level_before, level_after,
                  input ready);
  modport sink (input valid, chunk_len, level_before, level_after,
                output ready);
endinterface
`default_nettype wire

// File: hw/rtl/vfr_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none
module vfr_divider (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [vfr_pkg::LEN_W-1:0]   dividend,
  input  logic [vfr_pkg::DEN_W-1:0]   divisor,
  output logic                        done,
  output logic [vfr_pkg::LEN_W-1:0]   quotient
);

  logic                             busy_r, busy_nxt;
  logic                             done_r, done_nxt;
  logic [vfr_pkg::STEP_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [vfr_pkg::DEN_W-1:0]        den_r, den_nxt;
  logic [vfr_pkg::DEN_W-1:0]        rem_r, rem_nxt;
  logic [vfr_pkg::LEN_W-1:0]        quo_r, quo_nxt;
  logic [vfr_pkg::DEN_W:0]          trial;
  logic                             fits;

  always_comb begin
    trial    = {rem_r, quo_r[vfr_pkg::LEN_W-1]};
    fits     = trial >= {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      den_nxt  = divisor;
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      // shift in the next dividend bit, subtract where the divisor fits
      rem_nxt = fits ? vfr_pkg::DEN_W'(trial - {1'b0, den_r})
                     : trial[vfr_pkg::DEN_W-1:0];
      quo_nxt = {quo_r[vfr_pkg::LEN_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == vfr_pkg::STEP_CNT_W'(vfr_pkg::LEN_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// File: hw/rtl/vfr_fader.sv
// Fade state: level, target, step length and countdown, with their update.
`default_nettype none
module vfr_fader (
  input  logic                      clk,
  input  logic                      rst_n,
  input  vfr_pkg::vfr_op_t          op,
  output logic [vfr_pkg::LVL_W-1:0] level,
  output vfr_pkg::vfr_res_t         res
);

  logic [vfr_pkg::LVL_W-1:0] level_r, level_nxt;
  logic [vfr_pkg::LVL_W-1:0] target_r, target_nxt;
  logic [vfr_pkg::LEN_W-1:0] step_r, step_nxt;
  logic [vfr_pkg::LEN_W-1:0] rem_r, rem_nxt;

  logic                      same;
  logic                      short_len;
  logic                      fading;
  logic                      rem_less;
  logic [vfr_pkg::CNT_W-1:0] chunk;
  logic [vfr_pkg::LEN_W-1:0] rem_dec;
  logic                      up;
  logic [vfr_pkg::LVL_W-1:0] diff;
  logic [vfr_pkg::LVL_W-1:0] delta;
  logic [vfr_pkg::LVL_W-1:0] stepped;

  always_comb begin
    same      = op.tgt == level_r;
    short_len = op.len < vfr_pkg::LEN_W'(vfr_pkg::STEP_MIN);
    fading    = target_r != level_r;
    rem_less  = vfr_pkg::LEN_W'(op.n) < rem_r;
    chunk     = (fading && !rem_less) ? rem_r[vfr_pkg::CNT_W-1:0] : op.n;
    rem_dec   = rem_r - vfr_pkg::LEN_W'(chunk);
    up        = target_r > level_r;
    diff      = up ? target_r - level_r : level_r - target_r;
    delta     = (diff >= vfr_pkg::LVL_W'(vfr_pkg::LVL_STEP))
                ? vfr_pkg::LVL_W'(vfr_pkg::LVL_STEP) : diff;
    stepped   = up ? level_r + delta : level_r - delta;

    level_nxt  = level_r;
    target_nxt = target_r;
    step_nxt   = step_r;
    rem_nxt    = rem_r;
    if (op.is_adv) begin
      if (fading && chunk != '0) begin
        rem_nxt = rem_dec;
        // countdown expired: take one step and reload
        if (rem_dec == '0) begin
          level_nxt = stepped;
          rem_nxt   = step_r;
        end
      end
    end else if (!same) begin
      target_nxt = op.tgt;
      if (short_len) begin
        level_nxt = op.tgt;
        step_nxt  = '0;
        rem_nxt   = '0;
      end else begin
        step_nxt = op.len;
        rem_nxt  = op.len;
      end
    end

    res.chunk       = (op.is_adv && (fading ? chunk != '0 : 1'b1)) ? chunk : '0;
    res.level_after = level_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r  <= '0;
      target_r <= '0;
      step_r   <= '0;
      rem_r    <= '0;
    end else if (op.commit) begin
      level_r  <= level_nxt;
      target_r <= target_nxt;
      step_r   <= step_nxt;
      rem_r    <= rem_nxt;
    end
  end

  assign level = level_r;

endmodule
`default_nettype wire

// File: hw/rtl/volume_fade_ramp.sv
// Top level of the volume fade ramp: sequencer, divider, fade state, result register.
//
// Usage: items arrive on in_if (valid/ready). An item with action retarget sets a
// new target level and fade time; an item with action advance asks for up to
// sample_count samples and gets back in chunk_len how many play at level_before.
// Every item yields exactly one result on out_if (valid/ready), in order.
// Advance items, and retargets to the level already in effect, go from ST_IDLE
// straight to ST_DONE and reach the result register when they commit there.
// Other retargets pass through ST_DIV first: the step length comes from a
// bit-serial divider that produces one of its 25 quotient bits per cycle.
// A new item is accepted only in ST_IDLE, once the one before it has committed.
// The result register decouples the two sides: the next item is accepted while
// a result waits, but that item is only committed once the register is free, so
// a stalled receiver holds the block after at most one extra item.
// Synchronous reset (rst_n low) sets level, target, step length and countdown
// to zero and empties the result register.
`default_nettype none
module volume_fade_ramp (
  input  logic              clk,
  input  logic              rst_n,
  vfr_in_if.sink            in_if,
  vfr_out_if.source         out_if
);

  vfr_pkg::vfr_state_t state_r, state_nxt;

  logic                      act_r;
  logic [vfr_pkg::LVL_W-1:0] tgt_r;
  logic [vfr_pkg::CNT_W-1:0] n_r;
  logic [vfr_pkg::LVL_W-1:0] before_r;

  logic                      out_valid_r, out_valid_nxt;
  logic [vfr_pkg::CNT_W-1:0] chunk_r;
  logic [vfr_pkg::LVL_W-1:0] out_before_r;
  logic [vfr_pkg::LVL_W-1:0] after_r;

  logic                      in_ready;
  logic                      accept;
  logic                      div_start;
  logic                      out_free;
  logic                      commit;

  logic [vfr_pkg::LVL_W-1:0] level;
  logic [vfr_pkg::LVL_W-1:0] lvl_gap;
  logic [vfr_pkg::DEN_W+1:0] den_full;
  logic [vfr_pkg::LEN_W-1:0] num;
  logic                      div_done;
  logic [vfr_pkg::LEN_W-1:0] quotient;

  vfr_pkg::vfr_op_t          op;
  vfr_pkg::vfr_res_t         res;

  // Step length operands straight from the incoming item
  always_comb begin
    lvl_gap  = (in_if.target_level > level) ? in_if.target_level - level
                                            : level - in_if.target_level;
    den_full = (vfr_pkg::DEN_W+2)'(lvl_gap) * (vfr_pkg::DEN_W+2)'(vfr_pkg::DEN_MUL);
    num      = vfr_pkg::LEN_W'(in_if.fade_ms * vfr_pkg::RATE_NUM);
  end

  // Handshake and sequencing strobes
  always_comb begin
    in_ready  = state_r == vfr_pkg::ST_IDLE;
    accept    = in_ready && in_if.valid;
    div_start = accept && (in_if.action == vfr_pkg::ACT_RETARGET)
                && (in_if.target_level != level);
    out_free  = !out_valid_r || out_if.ready;
    commit    = (state_r == vfr_pkg::ST_DONE) && out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vfr_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = div_start ? vfr_pkg::ST_DIV : vfr_pkg::ST_DONE;
        end
      end
      vfr_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = vfr_pkg::ST_DONE;
        end
      end
      vfr_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = vfr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = vfr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    op.commit = commit;
    op.is_adv = act_r == vfr_pkg::ACT_ADVANCE;
    op.tgt    = tgt_r;
    op.n      = n_r;
    op.len    = quotient;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  vfr_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (num),
    .divisor  (den_full[vfr_pkg::DEN_W+1:2]),
    .done     (div_done),
    .quotient (quotient)
  );

  vfr_fader u_fader (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (op),
    .level (level),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vfr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the item while it is worked on, then load the result
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r    <= in_if.action;
      tgt_r    <= in_if.target_level;
      n_r      <= in_if.sample_count;
      before_r <= level;
    end
    if (commit) begin
      chunk_r      <= res.chunk;
      out_before_r <= before_r;
      after_r      <= res.level_after;
    end
  end

  assign in_if.ready         = in_ready;
  assign out_if.valid        = out_valid_r;
  assign out_if.chunk_len    = chunk_r;
  assign out_if.level_before = out_before_r;
  assign out_if.level_after  = after_r;

endmodule
`default_nettype wire
